FILE: hdl/vfd_pkg.sv
`default_nettype none

package vfd_pkg;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam logic [7:0] VelType    = 8'h20;
  localparam logic [7:0] VelLength  = 8'd12;

  localparam int FrameBytes = 17;
  localparam int PosW       = $clog2(FrameBytes);

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosHunt     = pos_t'(0);
  localparam pos_t PosHeld     = pos_t'(1);
  localparam pos_t PosType     = pos_t'(2);
  localparam pos_t PosLength   = pos_t'(3);
  localparam pos_t PosLinear0  = pos_t'(4);
  localparam pos_t PosLinear3  = pos_t'(7);
  localparam pos_t PosAngular0 = pos_t'(8);
  localparam pos_t PosAngular3 = pos_t'(11);
  localparam pos_t PosInterval = pos_t'(12);
  localparam pos_t PosIntervHi = pos_t'(13);
  localparam pos_t PosSequence = pos_t'(14);
  localparam pos_t PosSeqHi    = pos_t'(15);
  localparam pos_t PosCheck    = pos_t'(FrameBytes - 1);

  localparam int TagDepth = 2;
  localparam int ResDepth = 2;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusType   = 2'd1,
    StatusLength = 2'd2,
    StatusSum    = 2'd3
  } status_e;

  typedef struct packed {
    pos_t       pos;
    logic [7:0] data;
  } tag_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] linear;
    logic [31:0] angular;
    logic [15:0] interval;
    logic [15:0] sequence_no;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/velocity_frame_deframer.sv
// Byte-serial deframer for 17-byte velocity frames (0xAA 0x55, type, length,
// twelve payload bytes, additive checksum). It takes one byte per clock cycle
// while full is low, and every completed frame yields one result whose status
// reports a wrong type, a wrong length or a checksum mismatch, in that
// priority, or else success; the payload fields always carry the bytes as
// received. A front stage hunts for sync and tags each byte after the sync
// pair with its position, a short queue carries tagged bytes to an assembler,
// and a result queue holds finished frames. A result becomes visible once the
// checksum byte has passed through the tag queue and into the result queue;
// full rises only when both queues have backed up.
`default_nettype none

module velocity_frame_deframer #(
  parameter int TagDepth = vfd_pkg::TagDepth,
  parameter int ResDepth = vfd_pkg::ResDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       frame_status_o,
  output logic [31:0]      linear_bits_o,
  output logic [31:0]      angular_bits_o,
  output logic [15:0]      interval_ms_o,
  output logic [15:0]      sequence_res_o
);

  localparam int TagW = $bits(vfd_pkg::tag_t);
  localparam int ResW = $bits(vfd_pkg::result_t);

  vfd_pkg::tag_t    tag_in, tag_out;
  vfd_pkg::result_t res_in, res_out;
  logic             tag_push, tag_full, tag_pop, tag_empty;
  logic             res_push, res_full;
  logic [TagW-1:0]  tag_raw;
  logic [ResW-1:0]  res_raw;

  vfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .tag_full_i (tag_full),
    .tag_push_o (tag_push),
    .tag_o      (tag_in)
  );

  vfd_fifo #(
    .Width (TagW),
    .Depth (TagDepth)
  ) u_tag_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tag_push),
    .data_i  (tag_in),
    .full_o  (tag_full),
    .pop_i   (tag_pop),
    .data_o  (tag_raw),
    .empty_o (tag_empty)
  );

  assign tag_out = vfd_pkg::tag_t'(tag_raw);

  vfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_valid_i (!tag_empty),
    .tag_i       (tag_out),
    .tag_pop_o   (tag_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  vfd_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out        = vfd_pkg::result_t'(res_raw);
  assign frame_status_o = res_out.status;
  assign linear_bits_o  = res_out.linear;
  assign angular_bits_o = res_out.angular;
  assign interval_ms_o  = res_out.interval;
  assign sequence_res_o = res_out.sequence_no;

endmodule

`default_nettype wire

FILE: hdl/vfd_fifo.sv
`default_nettype none

module vfd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vfd_front.sv
`default_nettype none

module vfd_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             full_o,
  input  wire logic        tag_full_i,
  output logic             tag_push_o,
  output vfd_pkg::tag_t    tag_o
);

  vfd_pkg::pos_t pos_q, pos_d;
  logic [7:0]    first_q, first_d;
  logic          accept;

  assign full_o = tag_full_i;
  assign accept = push_i && !tag_full_i;

  assign tag_o.pos  = pos_q;
  assign tag_o.data = rx_byte_i;

  always_comb begin
    pos_d      = pos_q;
    first_d    = first_q;
    tag_push_o = 1'b0;
    if (accept) begin
      priority if (pos_q == vfd_pkg::PosHunt || pos_q > vfd_pkg::PosCheck) begin
        first_d = rx_byte_i;
        pos_d   = vfd_pkg::PosHeld;
      end else if (pos_q == vfd_pkg::PosHeld) begin
        if (first_q == vfd_pkg::SyncFirst && rx_byte_i == vfd_pkg::SyncSecond) begin
          pos_d = vfd_pkg::PosType;
        end else begin
          first_d = rx_byte_i;
        end
      end else begin
        tag_push_o = 1'b1;
        pos_d      = (pos_q == vfd_pkg::PosCheck) ? vfd_pkg::PosHunt : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= vfd_pkg::PosHunt;
      first_q <= '0;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vfd_back.sv
`default_nettype none

module vfd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           tag_valid_i,
  input  wire vfd_pkg::tag_t  tag_i,
  output logic                tag_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output vfd_pkg::result_t    res_o
);

  logic [7:0]  type_q, len_q, sum_q, sum_d;
  logic [31:0] linear_q, angular_q;
  logic [15:0] interval_q, seq_q;
  logic        is_check;

  assign is_check   = (tag_i.pos == vfd_pkg::PosCheck);
  assign tag_pop_o  = tag_valid_i && !(is_check && res_full_i);
  assign res_push_o = tag_pop_o && is_check;
  assign sum_d      = sum_q + tag_i.data;

  always_comb begin
    res_o.linear      = linear_q;
    res_o.angular     = angular_q;
    res_o.interval    = interval_q;
    res_o.sequence_no = seq_q;
    priority if (type_q != vfd_pkg::VelType) begin
      res_o.status = vfd_pkg::StatusType;
    end else if (len_q != vfd_pkg::VelLength) begin
      res_o.status = vfd_pkg::StatusLength;
    end else if (sum_q != tag_i.data) begin
      res_o.status = vfd_pkg::StatusSum;
    end else begin
      res_o.status = vfd_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q     <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      linear_q   <= '0;
      angular_q  <= '0;
      interval_q <= '0;
      seq_q      <= '0;
    end else if (tag_pop_o) begin
      if (tag_i.pos == vfd_pkg::PosType) begin
        type_q <= tag_i.data;
        sum_q  <= tag_i.data;
      end else begin
        sum_q <= sum_d;
      end
      if (tag_i.pos == vfd_pkg::PosLength) begin
        len_q <= tag_i.data;
      end
      if (tag_i.pos >= vfd_pkg::PosLinear0 && tag_i.pos <= vfd_pkg::PosLinear3) begin
        linear_q[8*tag_i.pos[1:0] +: 8] <= tag_i.data;
      end
      if (tag_i.pos >= vfd_pkg::PosAngular0 && tag_i.pos <= vfd_pkg::PosAngular3) begin
        angular_q[8*tag_i.pos[1:0] +: 8] <= tag_i.data;
      end
      if (tag_i.pos == vfd_pkg::PosInterval || tag_i.pos == vfd_pkg::PosIntervHi) begin
        interval_q[8*tag_i.pos[0] +: 8] <= tag_i.data;
      end
      if (tag_i.pos == vfd_pkg::PosSequence || tag_i.pos == vfd_pkg::PosSeqHi) begin
        seq_q[8*tag_i.pos[0] +: 8] <= tag_i.data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  frame_status_o;
  logic [31:0] linear_bits_o;
  logic [31:0] angular_bits_o;
  logic [15:0] interval_ms_o;
  logic [15:0] sequence_res_o;

  velocity_frame_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .frame_status_o (frame_status_o),
    .linear_bits_o  (linear_bits_o),
    .angular_bits_o (angular_bits_o),
    .interval_ms_o  (interval_ms_o),
    .sequence_res_o (sequence_res_o)
  );

  always #1 clk_i = ~clk_i;

  logic [7:0]        rx_backlog[$];
  vfd_pkg::result_t  frames_due[$];
  int                bytes_queued = 0;
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                byte_taken = 1'b0;

  // Deframer state as the testbench tracks it.
  int          held = 0;
  logic [7:0]  hunt_byte = '0;
  logic [7:0]  type_seen = '0;
  logic [7:0]  length_seen = '0;
  logic [7:0]  frame_sum = '0;
  logic [31:0] linear_acc = '0;
  logic [31:0] angular_acc = '0;
  logic [15:0] interval_acc = '0;
  logic [15:0] seqno_acc = '0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void deframe_byte(input logic [7:0] b);
    int               pos;
    vfd_pkg::result_t done;
    pos = held;
    if (pos >= vfd_pkg::FrameBytes) pos = 0;
    if (pos == 0) begin
      hunt_byte = b;
      held = 1;
    end else if (pos == 1) begin
      if (hunt_byte == vfd_pkg::SyncFirst && b == vfd_pkg::SyncSecond) begin
        held = 2;
      end else begin
        hunt_byte = b;
        held = 1;
      end
    end else if (pos == vfd_pkg::FrameBytes - 1) begin
      if (type_seen != vfd_pkg::VelType) done.status = vfd_pkg::StatusType;
      else if (length_seen != vfd_pkg::VelLength) done.status = vfd_pkg::StatusLength;
      else if (frame_sum != b) done.status = vfd_pkg::StatusSum;
      else done.status = vfd_pkg::StatusOk;
      done.linear = linear_acc;
      done.angular = angular_acc;
      done.interval = interval_acc;
      done.sequence_no = seqno_acc;
      frames_due = {frames_due, done};
      held = 0;
    end else begin
      if (pos == 2) begin
        type_seen = b;
        frame_sum = b;
      end else begin
        frame_sum = frame_sum + b;
        if (pos == 3) length_seen = b;
        else if (pos < 8) linear_acc[8*(pos-4) +: 8] = b;
        else if (pos < 12) angular_acc[8*(pos-8) +: 8] = b;
        else if (pos < 14) interval_acc[8*(pos-12) +: 8] = b;
        else seqno_acc[8*(pos-14) +: 8] = b;
      end
      held = pos + 1;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    rx_backlog = {rx_backlog, b};
    bytes_queued++;
  endfunction

  function automatic void queue_noise(input int count);
    for (int i = 0; i < count; i++) queue_byte(8'($urandom));
  endfunction

  function automatic void queue_frame(input logic [7:0] kind, input logic [7:0] len,
                                      input logic [95:0] body, input bit bad_sum);
    logic [7:0] sum;
    sum = kind + len;
    queue_byte(vfd_pkg::SyncFirst);
    queue_byte(vfd_pkg::SyncSecond);
    queue_byte(kind);
    queue_byte(len);
    for (int i = 0; i < 12; i++) begin
      queue_byte(body[8*i +: 8]);
      sum = sum + body[8*i +: 8];
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    queue_byte(sum);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      deframe_byte(rx_byte);
      void'(rx_backlog.pop_front());
      byte_taken = 1'b1;
    end else begin
      byte_taken = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!(push && !byte_taken)) begin
      if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        rx_byte <= rx_backlog[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    vfd_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (frames_due.size() == 0) begin
        flag_error("result popped with no frame completed");
      end else begin
        want = frames_due.pop_front();
        if (frame_status_o !== want.status)
          flag_error($sformatf("status %0d, expected %0d", frame_status_o, want.status));
        if (linear_bits_o !== want.linear)
          flag_error($sformatf("linear %h, expected %h", linear_bits_o, want.linear));
        if (angular_bits_o !== want.angular)
          flag_error($sformatf("angular %h, expected %h", angular_bits_o, want.angular));
        if (interval_ms_o !== want.interval)
          flag_error($sformatf("interval %h, expected %h", interval_ms_o, want.interval));
        if (sequence_res_o !== want.sequence_no)
          flag_error($sformatf("sequence %h, expected %h", sequence_res_o,
                               want.sequence_no));
      end
    end
  end

  initial begin
    int send_pct [4];
    int stall_pct [4];
    int goal;
    send_pct = '{0, 68, 0, 12};
    stall_pct = '{0, 0, 68, 12};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_stall_pct = stall_pct[ph];
      if (ph == 0) begin
        // A sync miss that keeps the newer byte, then the extremes of the
        // payload and every rejection, including the status priority.
        queue_byte(vfd_pkg::SyncSecond);
        queue_byte(vfd_pkg::SyncFirst);
        queue_byte(vfd_pkg::SyncFirst);
        queue_frame(vfd_pkg::VelType, vfd_pkg::VelLength, '0, 1'b0);
        queue_frame(vfd_pkg::VelType, vfd_pkg::VelLength, '1, 1'b0);
        queue_frame(8'hFF, 8'h00, {3{$urandom}}, 1'b1);
        queue_frame(vfd_pkg::VelType, 8'hFF, {3{$urandom}}, 1'b1);
        queue_frame(vfd_pkg::VelType, vfd_pkg::VelLength,
                    {$urandom, $urandom, $urandom}, 1'b1);
      end
      goal = bytes_queued + 285;
      while (bytes_queued < goal) begin
        if ($urandom_range(3) == 0) queue_noise($urandom_range(1, 4));
        if ($urandom_range(9) == 0) begin
          queue_byte(vfd_pkg::SyncFirst);
          queue_byte(8'($urandom));
        end
        queue_frame(($urandom_range(9) == 0) ? 8'($urandom) : vfd_pkg::VelType,
                    ($urandom_range(9) == 0) ? 8'($urandom) : vfd_pkg::VelLength,
                    {$urandom, $urandom, $urandom}, $urandom_range(9) == 0);
      end
      while (rx_backlog.size() != 0) @(posedge clk_i);
    end
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/vfd_pkg.sv
hdl/vfd_fifo.sv
hdl/vfd_front.sv
hdl/vfd_back.sv
hdl/velocity_frame_deframer.sv
dv/tb.sv
